// File: design/srr_pkg.sv
package srr_pkg;

   localparam int RAW_W   = 64;
   localparam int RANGE_W = 32;
   localparam int FRAC_W  = 24;
   localparam int FRACTION_SHIFT = 40;
   localparam int DIV_STEPS = RAW_W;
   localparam int COUNT_W = $clog2(DIV_STEPS);

   localparam logic [RAW_W-1:0] GOLDEN_INCREMENT = 64'h9e3779b97f4a7c15;
   localparam logic [RAW_W-1:0] MIX_MULT_A       = 64'hbf58476d1ce4e5b9;
   localparam logic [RAW_W-1:0] MIX_MULT_B       = 64'h94d049bb133111eb;

   typedef struct packed {
      logic               mode;
      logic [RAW_W-1:0]   seed_value;
      logic [RANGE_W-1:0] range_low;
      logic [RANGE_W-1:0] range_high;
   } req_type;

   typedef struct packed {
      logic [RAW_W-1:0]   raw_value;
      logic [FRAC_W-1:0]  unit_fraction;
      logic [RANGE_W-1:0] ranged_value;
      logic               advanced;
   } rsp_type;

   typedef enum logic [1:0] {
      SHIFT_30 = 2'd0,
      SHIFT_27 = 2'd1,
      SHIFT_31 = 2'd2
   } shift_sel_type;

   typedef enum logic [1:0] {
      MP_IDLE = 2'd0,
      MP_LL   = 2'd1,
      MP_LH   = 2'd2,
      MP_HL   = 2'd3
   } mul_part_type;

   typedef enum logic {
      ROUND_A = 1'b0,
      ROUND_B = 1'b1
   } mul_round_type;

   typedef struct packed {
      logic          capture;
      logic          load_seed;
      logic          advance;
      logic          shift_en;
      shift_sel_type shift_sel;
      mul_part_type  mul_part;
      mul_round_type mul_round;
      logic          div_init;
      logic          div_step;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_empty;
      logic div_last;
   } status_type;

endpackage

// File: design/splitmix_ranged_random_core.sv
// splitmix64 random source with ranged output
// req channel: one transaction is either a seed load (mode 1) or a draw
// (mode 0) over the inclusive range range_low..range_high
// rsp channel: exactly one transaction per request, in request order,
// carrying raw 64-bit draw, 0.24 fraction, ranged value and advanced flag
// seed load and empty range: the request passes EVAL, then DONE writes
// the result to the output register
// draw: the path runs through the 64-step restoring divider for the
// modulo plus two mixing rounds on one shared 32x32 multiplier
// (three partial products each)
// one request is processed at a time; req_stall is high from acceptance
// until the result has been written to the output register
// the output register frees the input side: a new request is taken while
// the previous result is still stalled, and the engine waits in its last
// step only when a second result is ready before the first is taken
// reset clears the generator state to zero and drops rsp_valid
module splitmix_ranged_random_core
   import srr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   srr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// File: design/srr_controller.sv
module srr_controller
   import srr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_EVAL     = 14'b00000000000010,
      ST_SHIFT1   = 14'b00000000000100,
      ST_MUL_LL1  = 14'b00000000001000,
      ST_MUL_LH1  = 14'b00000000010000,
      ST_MUL_HL1  = 14'b00000000100000,
      ST_SHIFT2   = 14'b00000001000000,
      ST_MUL_LL2  = 14'b00000010000000,
      ST_MUL_LH2  = 14'b00000100000000,
      ST_MUL_HL2  = 14'b00001000000000,
      ST_SHIFT3   = 14'b00010000000000,
      ST_DIV_INIT = 14'b00100000000000,
      ST_DIV      = 14'b01000000000000,
      ST_DONE     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.shift_sel = SHIFT_30;
      cmd.mul_part  = MP_IDLE;
      cmd.mul_round = ROUND_A;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.is_load) begin
               cmd.load_seed = 1'b1;
               state_in      = ST_DONE;
            end else if (status.is_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_SHIFT1;
            end
         end
         ST_SHIFT1: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SHIFT_30;
            state_in      = ST_MUL_LL1;
         end
         ST_MUL_LL1: begin
            cmd.mul_part = MP_LL;
            state_in     = ST_MUL_LH1;
         end
         ST_MUL_LH1: begin
            cmd.mul_part = MP_LH;
            state_in     = ST_MUL_HL1;
         end
         ST_MUL_HL1: begin
            cmd.mul_part = MP_HL;
            state_in     = ST_SHIFT2;
         end
         ST_SHIFT2: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SHIFT_27;
            state_in      = ST_MUL_LL2;
         end
         ST_MUL_LL2: begin
            cmd.mul_part  = MP_LL;
            cmd.mul_round = ROUND_B;
            state_in      = ST_MUL_LH2;
         end
         ST_MUL_LH2: begin
            cmd.mul_part  = MP_LH;
            cmd.mul_round = ROUND_B;
            state_in      = ST_MUL_HL2;
         end
         ST_MUL_HL2: begin
            cmd.mul_part  = MP_HL;
            cmd.mul_round = ROUND_B;
            state_in      = ST_SHIFT3;
         end
         ST_SHIFT3: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = SHIFT_31;
            state_in      = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/srr_datapath.sv
module srr_datapath
   import srr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   output rsp_type    rsp_data,
   input  cmd_type    cmd,
   output status_type status
);

   logic [RAW_W-1:0]     gen_state_ff, gen_state_in;
   logic                 mode_ff, empty_ff;
   logic [RAW_W-1:0]     seed_ff;
   logic [RANGE_W-1:0]   low_ff, high_ff;
   logic [RAW_W-1:0]     word_ff, word_in;
   logic [RAW_W-1:0]     acc_ff, acc_in;
   logic [RAW_W-1:0]     quot_ff, quot_in;
   logic [RANGE_W-1:0]   rem_ff, rem_in;
   logic [RANGE_W:0]     span_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   rsp_type              rsp_ff, rsp_in;

   logic [RAW_W-1:0]     mult_const;
   logic [RANGE_W-1:0]   mul_a, mul_b;
   logic [RAW_W-1:0]     product;
   logic [RAW_W-1:0]     shifted;
   logic [RANGE_W:0]     trial;
   logic [RANGE_W:0]     trial_diff;

   // mixing: xor-shift, then 64-bit low product over three partial steps
   always_comb begin
      case (cmd.shift_sel)
         SHIFT_30: shifted = word_ff >> 30;
         SHIFT_27: shifted = word_ff >> 27;
         SHIFT_31: shifted = word_ff >> 31;
         default:  shifted = word_ff >> 30;
      endcase
   end

   assign mult_const = (cmd.mul_round == ROUND_B) ? MIX_MULT_B : MIX_MULT_A;

   always_comb begin
      case (cmd.mul_part)
         MP_LL: begin
            mul_a = word_ff[RANGE_W-1:0];
            mul_b = mult_const[RANGE_W-1:0];
         end
         MP_LH: begin
            mul_a = word_ff[RANGE_W-1:0];
            mul_b = mult_const[RAW_W-1:RANGE_W];
         end
         MP_HL: begin
            mul_a = word_ff[RAW_W-1:RANGE_W];
            mul_b = mult_const[RANGE_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = RAW_W'(mul_a) * RAW_W'(mul_b);

   always_comb begin
      gen_state_in = gen_state_ff;
      word_in      = word_ff;
      acc_in       = acc_ff;
      if (cmd.load_seed) begin
         gen_state_in = seed_ff;
      end
      if (cmd.advance) begin
         gen_state_in = gen_state_ff + GOLDEN_INCREMENT;
         word_in      = gen_state_ff + GOLDEN_INCREMENT;
      end
      if (cmd.shift_en) begin
         word_in = word_ff ^ shifted;
      end
      case (cmd.mul_part)
         MP_LL: acc_in = product;
         MP_LH: acc_in = {acc_ff[RAW_W-1:RANGE_W] + product[RANGE_W-1:0],
                          acc_ff[RANGE_W-1:0]};
         MP_HL: word_in = {acc_ff[RAW_W-1:RANGE_W] + product[RANGE_W-1:0],
                           acc_ff[RANGE_W-1:0]};
         default: acc_in = acc_ff;
      endcase
   end

   // restoring division for the remainder, one dividend bit per cycle
   assign trial      = {rem_ff, quot_ff[RAW_W-1]};
   assign trial_diff = trial - span_ff;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      if (cmd.div_init) begin
         quot_in  = word_ff;
         rem_in   = '0;
         count_in = '0;
      end else if (cmd.div_step) begin
         quot_in  = {quot_ff[RAW_W-2:0], 1'b0};
         rem_in   = (trial >= span_ff) ? trial_diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in = '0;
         if (!mode_ff) begin
            if (empty_ff) begin
               rsp_in.ranged_value = low_ff;
            end else begin
               rsp_in.raw_value     = word_ff;
               rsp_in.unit_fraction = word_ff[FRACTION_SHIFT +: FRAC_W];
               rsp_in.ranged_value  = low_ff + rem_ff;
               rsp_in.advanced      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= '0;
      end else begin
         gen_state_ff <= gen_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_data.mode;
         empty_ff <= (req_data.range_high <= req_data.range_low);
         seed_ff  <= req_data.seed_value;
         low_ff   <= req_data.range_low;
         high_ff  <= req_data.range_high;
      end
      if (cmd.div_init) begin
         span_ff <= {1'b0, high_ff - low_ff} + 1'b1;
      end
      word_ff  <= word_in;
      acc_ff   <= acc_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   assign status.is_load  = mode_ff;
   assign status.is_empty = empty_ff;
   assign status.div_last = &count_ff;
   assign rsp_data        = rsp_ff;

endmodule
